### design/qas_pkg.sv
// Shared types and constants for the quoted argument splitter.
package qas_pkg;

    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_BS = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] MAX_ARGS_RESET = 8'd255;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_SQ    = 4'b0010,
        MODE_DQ    = 4'b0100,
        MODE_ESC   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       arg_end;
        logic       list_end;
        logic       parse_error;
        logic [7:0] arg_count;
    } out_word_t;

    typedef struct packed {
        mode_t      mode;
        mode_t      resume_mode;
        logic       started;
        logic [7:0] count_done;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        mode:        MODE_PLAIN,
        resume_mode: MODE_PLAIN,
        started:     1'b0,
        count_done:  8'd0
    };

endpackage

### design/qas_step.sv
// Per-character parse step: next state and result word.
module qas_step #(
    parameter int unsigned COUNT_LIMIT = 255
) (
    input  qas_pkg::parse_state_t st,
    input  qas_pkg::in_word_t     word,
    input  logic [7:0]            max_args,
    output qas_pkg::parse_state_t st_next,
    output qas_pkg::out_word_t    res,
    output logic                  has_res
);

    logic [7:0]            lim;
    logic                  blank;
    logic                  emit;
    logic                  end_arg;
    logic                  err;
    qas_pkg::parse_state_t s;

    always_comb
    begin
        if (COUNT_LIMIT < 32'(max_args))
        begin
            lim = 8'(COUNT_LIMIT);
        end
        else
        begin
            lim = max_args;
        end
    end

    assign blank = (word.in_char == qas_pkg::CH_SPACE) ||
                   ((word.in_char >= qas_pkg::CH_TAB) && (word.in_char <= qas_pkg::CH_CR));

    always_comb
    begin
        s       = st;
        emit    = 1'b0;
        end_arg = 1'b0;
        err     = 1'b0;
        if (st.count_done < lim)
        begin
            unique case (st.mode)
                qas_pkg::MODE_PLAIN:
                begin
                    if (blank)
                    begin
                        if (st.started)
                        begin
                            end_arg   = 1'b1;
                            s.started = 1'b0;
                        end
                    end
                    else if (word.in_char == qas_pkg::CH_SQ)
                    begin
                        s.mode    = qas_pkg::MODE_SQ;
                        s.started = 1'b1;
                    end
                    else if (word.in_char == qas_pkg::CH_DQ)
                    begin
                        s.mode    = qas_pkg::MODE_DQ;
                        s.started = 1'b1;
                    end
                    else if (word.in_char == qas_pkg::CH_BS)
                    begin
                        s.mode        = qas_pkg::MODE_ESC;
                        s.resume_mode = qas_pkg::MODE_PLAIN;
                        s.started     = 1'b1;
                        emit          = 1'b1;
                    end
                    else
                    begin
                        s.started = 1'b1;
                        emit      = 1'b1;
                    end
                end
                qas_pkg::MODE_SQ, qas_pkg::MODE_DQ:
                begin
                    if (word.in_char == qas_pkg::CH_BS)
                    begin
                        s.resume_mode = st.mode;
                        s.mode        = qas_pkg::MODE_ESC;
                    end
                    else if ((st.mode == qas_pkg::MODE_SQ && word.in_char == qas_pkg::CH_SQ) ||
                             (st.mode == qas_pkg::MODE_DQ && word.in_char == qas_pkg::CH_DQ))
                    begin
                        s.mode = qas_pkg::MODE_PLAIN;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    // escaped char: back to the quote or plain mode we came from
                    if (st.resume_mode == qas_pkg::MODE_SQ || st.resume_mode == qas_pkg::MODE_DQ)
                    begin
                        s.mode = st.resume_mode;
                    end
                    else
                    begin
                        s.mode = qas_pkg::MODE_PLAIN;
                    end
                    s.started = 1'b1;
                    emit      = 1'b1;
                end
            endcase
        end

        if (word.last)
        begin
            if (s.mode != qas_pkg::MODE_PLAIN)
            begin
                err = 1'b1;
            end
            else if (s.started)
            begin
                end_arg   = 1'b1;
                s.started = 1'b0;
            end
        end
        if (end_arg)
        begin
            s.count_done = st.count_done + 8'd1;
        end

        res.has_char    = emit;
        res.out_char    = emit ? word.in_char : 8'd0;
        res.arg_end     = end_arg;
        res.list_end    = word.last;
        res.parse_error = err;
        res.arg_count   = s.count_done;
        has_res         = emit || end_arg || word.last;

        st_next = word.last ? qas_pkg::STATE_RESET : s;
    end

endmodule

### design/quoted_argument_splitter.sv
// Quoted argument splitter top level: input register, parse step, result register.
//
// Splits a command line into arguments, one character word per cycle.
// Input channel: in_valid / in_stall / in_word (in_char, last). A word is
// taken at an edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / out_word. One result word per
// input character that passes a character, ends an argument or ends the
// line; other characters give no result.
// Configuration: cfg_valid / cfg_ready / cfg_data writes max_args; cfg_ready
// is always high. Write only while no line is in flight.
// Path: a taken character passes the input register, then the result
// register, which presents its result; out_stall can hold it in between.
// Throughput: one character per cycle while the output is not stalled; the
// parse step is combinational, input register to state and result registers.
// Stall: out_stall holds the result register; a character waiting in the
// input register then holds, and in_stall rises while both are full.
// Reset: parse state clears, max_args returns to 255, both channels empty.
module quoted_argument_splitter #(
    parameter int unsigned COUNT_LIMIT = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  qas_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output qas_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    logic                  s1_valid_reg;
    qas_pkg::in_word_t     s1_word_reg;
    qas_pkg::parse_state_t st_reg;
    qas_pkg::parse_state_t st_next;
    logic [7:0]            max_args_reg;
    logic                  out_valid_reg;
    qas_pkg::out_word_t    out_reg;
    qas_pkg::out_word_t    res_next;
    logic                  has_res;
    logic                  s2_ready;
    logic                  s1_fire;

    assign cfg_ready = 1'b1;
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    qas_step #(
        .COUNT_LIMIT(COUNT_LIMIT)
    ) u_step (
        .st       (st_reg),
        .word     (s1_word_reg),
        .max_args (max_args_reg),
        .st_next  (st_next),
        .res      (res_next),
        .has_res  (has_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= qas_pkg::MAX_ARGS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_args_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= qas_pkg::STATE_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg && has_res;
            end
            if (s1_fire)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_word_reg <= in_word;
        end
        if (s1_fire)
        begin
            out_reg <= res_next;
        end
    end

    a_line_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_word_reg.last |=>
            st_reg.mode == qas_pkg::MODE_PLAIN && !st_reg.started && st_reg.count_done == 8'd0)
        else $error("parse state not cleared after end of line");

    a_error_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.parse_error |-> out_reg.list_end && !out_reg.arg_end)
        else $error("parse_error outside a clean end of line");

    a_no_char_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.has_char |-> out_reg.out_char == 8'd0)
        else $error("out_char set without has_char");

    a_arg_end_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.arg_end |-> out_reg.arg_count != 8'd0)
        else $error("argument ended with zero count");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule
